// File: src/nts_pkg.sv
// Shared types, widths and codes for the nearest tile direction search block.
package nts_pkg;

    localparam int TILE_W      = 12;
    localparam int COUNT_W     = 13;
    localparam int COORD_BITS  = 16;
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int SCORE_W     = PROD_W + 1;
    localparam int VEC_W       = 3 * COORD_BITS;

    localparam int MAX_TILES_DEF = 4096;

    // stream payload: slot + tile xyz + query xyz, padded to whole bytes
    localparam int IN_FIELDS_W = TILE_W + 2 * VEC_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TILE_W + SCORE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] TILE_COUNT_RST = COUNT_W'(12);

    // register index taken from paddr[2]
    localparam logic REG_TILE_COUNT = 1'b0;

    // operation codes carried in s_axis_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_tile_vec;

    // tag that travels with each table entry through the dot pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_dot_ctl;

endpackage

// File: src/nearest_tile_direction_search.sv
// Top level of the nearest tile direction search block.
//
// Usage:
//   s_axis carries one transaction per item. s_axis_tuser is the operation:
//   OP_WRITE stores tile_x/y/z at tile_slot, OP_QUERY searches the table.
//   m_axis returns one result per query: best_tile and best_score (Q3.30).
//   The APB register tile_count (address 0, reset 12) sets how many entries
//   a query scans; it is saturated to 1 .. MAX_TILES when a query starts.
// Flow:
//   A write gives no result. A query holds s_axis_tready low while it
//   scans and until its result is passed to the output register, so no
//   new item is taken before the last query is through. The table read
//   port and the shared dot product unit handle one entry per cycle, with
//   a four-stage read/multiply/sum/compare pipeline behind the address
//   issue.
// Reset and stall:
//   Reset is synchronous, clears the sequencer and output valid and sets
//   tile_count to 12; table contents are undefined until written. A result
//   waits in the output register while m_axis_tready is low; writes and a
//   new query are still taken, and a finished query waits for the register.
module nearest_tile_direction_search #(
    parameter int MAX_TILES = nts_pkg::MAX_TILES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s_axis_tdata: tile_slot[11:0], tile_x[27:12], tile_y[43:28],
    //   tile_z[59:44], query_x[75:60], query_y[91:76], query_z[107:92]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // s_axis_tuser: operation[0]
    input  logic                               s_axis_tuser,
    // m_axis_tdata: best_tile[11:0], best_score[44:12]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nts_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nts_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nts_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(MAX_TILES);

    localparam int CW = nts_pkg::COORD_BITS;
    localparam int TW = nts_pkg::TILE_W;

    logic [nts_pkg::COUNT_W-1:0]          r_tile_count;
    logic                                 r_m_tvalid;
    logic [nts_pkg::OUT_TDATA_W-1:0]      r_m_tdata;

    logic [TW-1:0]                        in_slot;
    nts_pkg::t_tile_vec                   in_tile;
    nts_pkg::t_tile_vec                   in_query;
    logic                                 wr_en;
    logic [IDX_W-1:0]                     wr_addr;
    nts_pkg::t_tile_vec                   wr_data;
    logic                                 rd_en;
    logic [IDX_W-1:0]                     rd_addr;
    nts_pkg::t_tile_vec                   rd_data;
    nts_pkg::t_tile_vec                   query;
    nts_pkg::t_dot_ctl                    rd_ctl;
    logic signed [nts_pkg::SCORE_W-1:0]   sum;
    nts_pkg::t_dot_ctl                    sum_ctl;
    logic                                 res_vld;
    logic                                 res_rdy;
    logic [TW-1:0]                        res_tile;
    logic signed [nts_pkg::SCORE_W-1:0]   res_score;

    // APB: single register, written on the access phase
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count <= nts_pkg::TILE_COUNT_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == nts_pkg::REG_TILE_COUNT)) begin
            r_tile_count <= pwdata[nts_pkg::COUNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == nts_pkg::REG_TILE_COUNT)
                  ? nts_pkg::APB_DATA_W'(r_tile_count) : '0;

    // unpack input payload
    assign in_slot    = s_axis_tdata[TW-1:0];
    assign in_tile.x  = s_axis_tdata[TW+CW-1   -: CW];
    assign in_tile.y  = s_axis_tdata[TW+2*CW-1 -: CW];
    assign in_tile.z  = s_axis_tdata[TW+3*CW-1 -: CW];
    assign in_query.x = s_axis_tdata[TW+4*CW-1 -: CW];
    assign in_query.y = s_axis_tdata[TW+5*CW-1 -: CW];
    assign in_query.z = s_axis_tdata[TW+6*CW-1 -: CW];

    nts_scan_ctrl #(
        .MAX_TILES (MAX_TILES),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_vld     (s_axis_tvalid),
        .o_in_rdy     (s_axis_tready),
        .i_in_op      (s_axis_tuser),
        .i_slot       (in_slot),
        .i_tile       (in_tile),
        .i_query      (in_query),
        .i_tile_count (r_tile_count),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_query      (query),
        .o_rd_ctl     (rd_ctl),
        .i_sum        (sum),
        .i_sum_ctl    (sum_ctl),
        .o_res_vld    (res_vld),
        .i_res_rdy    (res_rdy),
        .o_res_tile   (res_tile),
        .o_res_score  (res_score)
    );

    nts_tile_mem #(
        .DEPTH (MAX_TILES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nts_dot_unit u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (rd_data),
        .i_q     (query),
        .i_ctl   (rd_ctl),
        .o_sum   (sum),
        .o_ctl   (sum_ctl)
    );

    // output register parts the scan from a stalled receiver
    assign res_rdy = !r_m_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_m_tdata <= nts_pkg::OUT_TDATA_W'({res_score, res_tile});
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

// File: src/nts_tile_mem.sv
// Tile vector table: one write port, one registered read port.
module nts_tile_mem #(
    parameter int DEPTH = nts_pkg::MAX_TILES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  nts_pkg::t_tile_vec i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output nts_pkg::t_tile_vec o_rd_data
);

    nts_pkg::t_tile_vec r_mem [DEPTH];
    nts_pkg::t_tile_vec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/nts_dot_unit.sv
// Shared dot product unit: three products, registered, then a registered sum.
module nts_dot_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nts_pkg::t_tile_vec                  i_vec,
    input  nts_pkg::t_tile_vec                  i_q,
    input  nts_pkg::t_dot_ctl                   i_ctl,
    output logic signed [nts_pkg::SCORE_W-1:0]  o_sum,
    output nts_pkg::t_dot_ctl                   o_ctl
);

    logic signed [nts_pkg::PROD_W-1:0]  r_px;
    logic signed [nts_pkg::PROD_W-1:0]  r_py;
    logic signed [nts_pkg::PROD_W-1:0]  r_pz;
    logic signed [nts_pkg::SCORE_W-1:0] r_sum;
    nts_pkg::t_dot_ctl                  r_ctl1;
    nts_pkg::t_dot_ctl                  r_ctl2;

    always_ff @(posedge i_clk) begin
        r_px  <= i_vec.x * i_q.x;
        r_py  <= i_vec.y * i_q.y;
        r_pz  <= i_vec.z * i_q.z;
        // three Q2.30 products cannot overflow 33 bits
        r_sum <= nts_pkg::SCORE_W'(r_px) + nts_pkg::SCORE_W'(r_py)
               + nts_pkg::SCORE_W'(r_pz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    assign o_sum = r_sum;
    assign o_ctl = r_ctl2;

endmodule

// File: src/nts_scan_ctrl.sv
// Scan sequencer: table writes, address issue and running maximum of dot products.
module nts_scan_ctrl #(
    parameter int MAX_TILES = nts_pkg::MAX_TILES_DEF,
    parameter int IDX_W     = $clog2(MAX_TILES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transaction
    input  logic                                i_in_vld,
    output logic                                o_in_rdy,
    input  logic                                i_in_op,
    input  logic [nts_pkg::TILE_W-1:0]          i_slot,
    input  nts_pkg::t_tile_vec                  i_tile,
    input  nts_pkg::t_tile_vec                  i_query,
    input  logic [nts_pkg::COUNT_W-1:0]         i_tile_count,
    // table ports
    output logic                                o_wr_en,
    output logic [IDX_W-1:0]                    o_wr_addr,
    output nts_pkg::t_tile_vec                  o_wr_data,
    output logic                                o_rd_en,
    output logic [IDX_W-1:0]                    o_rd_addr,
    // dot unit
    output nts_pkg::t_tile_vec                  o_query,
    output nts_pkg::t_dot_ctl                   o_rd_ctl,
    input  logic signed [nts_pkg::SCORE_W-1:0]  i_sum,
    input  nts_pkg::t_dot_ctl                   i_sum_ctl,
    // result
    output logic                                o_res_vld,
    input  logic                                i_res_rdy,
    output logic [nts_pkg::TILE_W-1:0]          o_res_tile,
    output logic signed [nts_pkg::SCORE_W-1:0]  o_res_score
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [IDX_W-1:0]                    r_addr;
    logic [IDX_W-1:0]                    r_last_addr;
    logic [IDX_W-1:0]                    n_last_addr;
    logic [IDX_W-1:0]                    r_cmp_idx;
    logic [IDX_W-1:0]                    cur_idx;
    logic [IDX_W-1:0]                    r_best_idx;
    logic signed [nts_pkg::SCORE_W-1:0]  r_best_score;
    nts_pkg::t_tile_vec                  r_query;
    nts_pkg::t_dot_ctl                   r_rd_ctl;
    nts_pkg::t_dot_ctl                   issue_ctl;
    logic                                in_acc;
    logic                                q_start;
    logic                                take;
    logic [31:0]                         cnt_ext;
    logic [31:0]                         best_ext;

    assign o_in_rdy = (r_state == ST_IDLE);
    assign in_acc   = i_in_vld && o_in_rdy;
    assign q_start  = in_acc && (i_in_op == nts_pkg::OP_QUERY);

    assign o_wr_en   = in_acc && (i_in_op == nts_pkg::OP_WRITE)
                    && (32'(i_slot) < 32'(MAX_TILES));
    assign o_wr_addr = IDX_W'(i_slot);
    assign o_wr_data = i_tile;

    // saturate tile_count to 1 .. MAX_TILES, keep last index
    assign cnt_ext = 32'(i_tile_count);
    always_comb begin
        priority if (cnt_ext == 32'd0) begin
            n_last_addr = '0;
        end else if (cnt_ext >= 32'(MAX_TILES)) begin
            n_last_addr = IDX_W'(MAX_TILES - 1);
        end else begin
            n_last_addr = IDX_W'(cnt_ext - 32'd1);
        end
    end

    assign issue_ctl.vld   = (r_state == ST_ISSUE);
    assign issue_ctl.first = (r_addr == '0);
    assign issue_ctl.last  = (r_addr == r_last_addr);

    assign o_rd_en   = issue_ctl.vld;
    assign o_rd_addr = r_addr;
    assign o_rd_ctl  = r_rd_ctl;
    assign o_query   = r_query;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (q_start) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (issue_ctl.last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sum_ctl.vld && i_sum_ctl.last) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_res_rdy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_addr   <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= issue_ctl;  // aligned with registered table read
            if (q_start) begin
                r_addr <= '0;
            end else if (issue_ctl.vld) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_query     <= i_query;
            r_last_addr <= n_last_addr;
        end
    end

    // strict greater-than keeps the lowest index on ties
    assign cur_idx = i_sum_ctl.first ? '0 : r_cmp_idx;
    assign take    = i_sum_ctl.vld && (i_sum_ctl.first || (i_sum > r_best_score));

    always_ff @(posedge i_clk) begin
        if (i_sum_ctl.vld) begin
            r_cmp_idx <= cur_idx + 1'b1;
        end
        if (take) begin
            r_best_idx   <= cur_idx;
            r_best_score <= i_sum;
        end
    end

    assign best_ext    = 32'(r_best_idx);
    assign o_res_vld   = (r_state == ST_HOLD);
    assign o_res_tile  = best_ext[nts_pkg::TILE_W-1:0];
    assign o_res_score = r_best_score;

`ifndef SYNTHESIS
    a_sum_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sum_ctl.vld |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("dot result outside a scan");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_addr <= r_last_addr))
        else $error("scan address past tile count");

    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_HOLD) |-> $past(i_sum_ctl.vld && i_sum_ctl.last))
        else $error("result raised before last entry compared");

    a_cmp_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sum_ctl.vld && !i_sum_ctl.first) |-> (r_cmp_idx <= r_last_addr))
        else $error("compare index past tile count");
`endif

endmodule

// File: dv/nts_checker.sv
`timescale 1ns / 100ps
// Bus monitor, table shadow and result scoreboard for the nearest tile search block.
module nts_checker #(
    parameter int MAX_TILES = nts_pkg::MAX_TILES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // s_axis_tdata: tile_slot, tile_x, tile_y, tile_z, query_x, query_y, query_z
    input  logic [nts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // s_axis_tuser: operation
    input  logic                               s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // m_axis_tdata: best_tile, best_score
    input  logic [nts_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nts_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nts_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                               pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic [nts_pkg::TILE_W-1:0]         tile;
        logic signed [nts_pkg::SCORE_W-1:0] score;
    } t_answer;

    nts_pkg::t_tile_vec          tile_table [MAX_TILES];
    logic [nts_pkg::COUNT_W-1:0] tile_count_q = nts_pkg::TILE_COUNT_RST;
    t_answer                     pending_answers [$];
    int                          fails = 0;

    function automatic longint tile_dot(input nts_pkg::t_tile_vec tv,
                                        input nts_pkg::t_tile_vec qv);
        return longint'($signed(tv.x)) * longint'($signed(qv.x))
             + longint'($signed(tv.y)) * longint'($signed(qv.y))
             + longint'($signed(tv.z)) * longint'($signed(qv.z));
    endfunction

    // count saturates to 1..MAX_TILES; ties keep the lower index
    function automatic t_answer nearest_tile(input nts_pkg::t_tile_vec qv);
        int      span;
        int      i;
        longint  dot;
        longint  top_dot;
        t_answer ans;
        span = int'(tile_count_q);
        if (span == 0) span = 1;
        if (span > MAX_TILES) span = MAX_TILES;
        top_dot = tile_dot(tile_table[0], qv);
        ans.tile = '0;
        for (i = 1; i < span; i++) begin
            dot = tile_dot(tile_table[i], qv);
            if (dot > top_dot) begin
                top_dot = dot;
                ans.tile = nts_pkg::TILE_W'(i);
            end
        end
        ans.score = top_dot[nts_pkg::SCORE_W-1:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer                    got;
        t_answer                    want;
        nts_pkg::t_tile_vec         qv;
        logic [nts_pkg::TILE_W-1:0] slot;
        if (!i_rst_n) begin
            tile_count_q = nts_pkg::TILE_COUNT_RST;
            pending_answers.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[2] == nts_pkg::REG_TILE_COUNT) begin
                tile_count_q = pwdata[nts_pkg::COUNT_W-1:0];
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.tile  = m_axis_tdata[nts_pkg::TILE_W-1:0];
                got.score = m_axis_tdata[nts_pkg::TILE_W +: nts_pkg::SCORE_W];
                if (pending_answers.size() == 0) begin
                    $error("result with no query pending: best_tile %0d best_score %0d",
                           got.tile, got.score);
                    fails++;
                end else begin
                    want = pending_answers.pop_front();
                    if (got.tile !== want.tile) begin
                        $error("best_tile mismatch: expected %0d, actual %0d",
                               want.tile, got.tile);
                        fails++;
                    end
                    if (got.score !== want.score) begin
                        $error("best_score mismatch: expected %0d, actual %0d",
                               want.score, got.score);
                        fails++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                slot = s_axis_tdata[nts_pkg::TILE_W-1:0];
                if (s_axis_tuser == nts_pkg::OP_WRITE) begin
                    if (int'(slot) < MAX_TILES) begin
                        tile_table[slot] = s_axis_tdata[nts_pkg::TILE_W +: nts_pkg::VEC_W];
                    end
                end else begin
                    qv = s_axis_tdata[nts_pkg::TILE_W + nts_pkg::VEC_W +: nts_pkg::VEC_W];
                    pending_answers.insert(pending_answers.size(), nearest_tile(qv));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_answers.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the nearest tile direction search block.
module tb;

    localparam int MAX_TILES  = nts_pkg::MAX_TILES_DEF;
    localparam int FILL_CNT   = 24;
    localparam int SETTLE_CYC = 16;
    localparam int DRAIN_CYC  = 32;
    localparam logic [nts_pkg::APB_ADDR_W-1:0] TILE_COUNT_ADDR =
        {nts_pkg::REG_TILE_COUNT, 2'b00};

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_BEAT} t_rx_mode;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // s_axis_tdata: tile_slot, tile_x, tile_y, tile_z, query_x, query_y, query_z
    logic [nts_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // s_axis_tuser: operation
    logic                             s_axis_tuser = nts_pkg::OP_WRITE;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // m_axis_tdata: best_tile, best_score
    logic [nts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [nts_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [nts_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [nts_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    int       fails;
    int       pending;
    int       burst_left = 0;
    int       span = 12;
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always #5 i_clk = ~i_clk;

    nearest_tile_direction_search #(.MAX_TILES(MAX_TILES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    nts_checker #(.MAX_TILES(MAX_TILES)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fails),
        .o_pending     (pending)
    );

    // receiver backpressure: free, coin-flip, slow and beat modes, picked at random
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE: m_axis_tready <= 1'b1;
            RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SLOW: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= rx_tick[2];
        endcase
    end

    // corner values show up often so that ties and extreme sums are common
    function automatic logic [nts_pkg::COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return nts_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic nts_pkg::t_tile_vec rand_vec();
        nts_pkg::t_tile_vec v;
        v.x = rand_coord();
        v.y = rand_coord();
        v.z = rand_coord();
        return v;
    endfunction

    function automatic nts_pkg::t_tile_vec mk_vec(input int x, input int y, input int z);
        nts_pkg::t_tile_vec v;
        v.x = nts_pkg::COORD_BITS'(x);
        v.y = nts_pkg::COORD_BITS'(y);
        v.z = nts_pkg::COORD_BITS'(z);
        return v;
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic op, input logic [nts_pkg::TILE_W-1:0] slot,
                             input nts_pkg::t_tile_vec tile,
                             input nts_pkg::t_tile_vec qry);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= nts_pkg::IN_TDATA_W'({qry, tile, slot});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic reg_write(input logic [nts_pkg::APB_ADDR_W-1:0] addr,
                             input logic [nts_pkg::APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only reprogram once every query has answered and the pipe has drained
    task automatic set_tile_count(input int count);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        // upper bits are junk; only the low COUNT_W bits hold the register
        reg_write(TILE_COUNT_ADDR,
                  ($urandom & ~32'((1 << nts_pkg::COUNT_W) - 1)) | 32'(count));
        span = (count == 0) ? 1 : ((count > MAX_TILES) ? MAX_TILES : count);
    endtask

    // writes mostly land inside the scanned range so they change the answers
    task automatic random_items(input int n);
        logic [nts_pkg::TILE_W-1:0] slot;
        repeat (n) begin
            if ($urandom_range(0, 9) < 4) begin
                slot = ($urandom_range(0, 7) == 0)
                     ? nts_pkg::TILE_W'($urandom_range(0, MAX_TILES - 1))
                     : nts_pkg::TILE_W'($urandom_range(0, span - 1));
                send_item(nts_pkg::OP_WRITE, slot, rand_vec(), rand_vec());
            end else begin
                send_item(nts_pkg::OP_QUERY, nts_pkg::TILE_W'($urandom), rand_vec(),
                          ($urandom_range(0, 11) == 0) ? mk_vec(0, 0, 0) : rand_vec());
            end
        end
    endtask

    initial begin
        nts_pkg::t_tile_vec seed;
        int                 counts [$];
        int                 c;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the low entries; every tile count below stays inside them
        for (int slot = 0; slot < FILL_CNT; slot++) begin
            case (slot)
                0:       seed = mk_vec(0, 0, 0);
                1:       seed = mk_vec(32767, 0, 0);
                2:       seed = mk_vec(-32768, -32768, -32768);
                3:       seed = mk_vec(32767, 32767, 32767);
                4:       seed = mk_vec(0, 32767, 0);
                5:       seed = mk_vec(32767, 0, 0);    // same as entry 1: lower wins
                6:       seed = mk_vec(0, 0, -32768);
                7:       seed = mk_vec(-32768, 32767, -32768);
                8:       seed = mk_vec(32767, -32768, 32767);
                9:       seed = mk_vec(0, 0, 32767);
                10:      seed = mk_vec(23170, 23170, 0);
                11:      seed = mk_vec(-1, -1, -1);
                default: seed = rand_vec();
            endcase
            send_item(nts_pkg::OP_WRITE, nts_pkg::TILE_W'(slot), seed, rand_vec());
        end

        // directed queries at the reset tile count
        send_item(nts_pkg::OP_QUERY, '1, mk_vec(32767, 32767, 32767), mk_vec(0, 0, 0));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(32767, 32767, 32767));
        send_item(nts_pkg::OP_QUERY, '1, mk_vec(-1, 5, 9), mk_vec(-32768, -32768, -32768));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(32767, 0, 0));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(0, -32768, 0));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(0, 0, 1));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(-32768, 32767, -32768));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(1, -1, 1));
        // a write may carry query fields; they must not leak into the table
        send_item(nts_pkg::OP_WRITE, nts_pkg::TILE_W'(11), mk_vec(-32768, 0, 32767),
                  mk_vec(32767, 32767, 32767));
        send_item(nts_pkg::OP_QUERY, '0, mk_vec(0, 0, 0), mk_vec(-32768, 0, 32767));

        counts = '{0, 1, 2, 3, 5, 12, FILL_CNT, 17, int'($urandom_range(1, FILL_CNT))};
        foreach (counts[i]) begin
            c = counts[i];
            set_tile_count(c);
            random_items(12);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/nts_pkg.sv
src/nts_tile_mem.sv
src/nts_dot_unit.sv
src/nts_scan_ctrl.sv
src/nearest_tile_direction_search.sv
dv/nts_checker.sv
dv/tb.sv
